>>> sv/assert_macros.svh
// Assertion helpers used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define PFA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define PFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/pfa_pkg.sv
package pfa_pkg;

  // fit_mode codes
  localparam logic [2:0] MODE_FIRST     = 3'd0;
  localparam logic [2:0] MODE_NEXT      = 3'd1;
  localparam logic [2:0] MODE_BEST      = 3'd2;
  localparam logic [2:0] MODE_WORST     = 3'd3;
  localparam logic [2:0] MODE_WORST_DYN = 3'd4;

  // register indexes
  localparam logic CFG_FIT_MODE   = 1'b0;
  localparam logic CFG_PART_COUNT = 1'b1;

  // request types
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  // fixed field widths
  localparam int MODE_W     = 3;
  localparam int COUNT_W    = 5;
  localparam int INDEX_W    = 5;
  localparam int IN_SIZE_W  = 16;
  localparam int CFG_DATA_W = 5;

  // control of the shared candidate compare
  typedef struct packed {
    logic use_taken;
    logic want_min;
    logic want_max;
    logic have_pick;
  } cmp_ctl_t;

endpackage

>>> sv/pfa_cmp.sv
module pfa_cmp #(
  parameter int W = 16
) (
  input  pfa_pkg::cmp_ctl_t ctl,
  input  logic [W-1:0]      size,
  input  logic [W-1:0]      job,
  input  logic [W-1:0]      best,
  input  logic              taken,
  output logic              take
);
  import pfa_pkg::*;

  logic fits;
  logic better;

  // Same job for every candidate, so comparing sizes orders the waste.
  always_comb begin
    fits = !(ctl.use_taken && taken) && (size >= job);
    priority if (!ctl.have_pick) begin
      better = 1'b1;
    end else if (ctl.want_min) begin
      better = size < best;
    end else if (ctl.want_max) begin
      better = size > best;
    end else begin
      better = 1'b0;
    end
    take = fits && better;
  end

endmodule

>>> sv/partition_fit_allocator.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  req_type, part_index, part_size, job_size
// out      output     out_valid / out_stall granted, part_number, leftover
// cfg      input      cfg_we               cfg_index, cfg_data
//
// A load request is taken while idle. An allocate request scans one partition per
// cycle through the single read port of the size table and the shared compare, then
// posts its result. With nothing to scan (count 0, next-fit pointer past the end,
// unused mode) it goes straight to the result.
// Reset is synchronous, active low; it clears the size table (valid bits), the taken
// flags, rewinds the next-fit pointer to 1 and loads fit_mode 0, partition_count 16.
// A stalled result holds in the output register; a finished scan waits for it.
`include "assert_macros.svh"

module partition_fit_allocator #(
  parameter int MAX_PARTS = 16,
  parameter int SIZE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_req_type,
  input  logic [pfa_pkg::INDEX_W-1:0]    in_part_index,
  input  logic [pfa_pkg::IN_SIZE_W-1:0]  in_part_size,
  input  logic [pfa_pkg::IN_SIZE_W-1:0]  in_job_size,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_granted,
  output logic [pfa_pkg::INDEX_W-1:0]    out_part_number,
  output logic [pfa_pkg::IN_SIZE_W-1:0]  out_leftover,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [pfa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pfa_pkg::*;

  localparam int AW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;  // table address
  localparam int KW = $clog2(MAX_PARTS + 2);                    // 1-based number, up to N+1
  localparam int WW = (SIZE_BITS > IN_SIZE_W) ? SIZE_BITS : IN_SIZE_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t               state_r;
  logic [MODE_W-1:0]    fit_mode_r;
  logic [COUNT_W-1:0]   pcount_r;
  logic [KW-1:0]        ptr_r;
  logic [MAX_PARTS-1:0] taken_r;
  logic [MAX_PARTS-1:0] vld_r;

  logic [SIZE_BITS-1:0] mem [MAX_PARTS];
  logic [SIZE_BITS-1:0] rd_data_r;
  logic                 rd_v_r;
  logic [KW-1:0]        rd_k_r;

  logic [KW-1:0]        ctr_r;
  logic [KW-1:0]        end_r;
  logic [KW-1:0]        pick_r;
  logic [SIZE_BITS-1:0] best_r;
  logic [IN_SIZE_W-1:0] job_r;

  logic                 out_valid_r;
  logic                 out_granted_r;
  logic [INDEX_W-1:0]   out_part_number_r;
  logic [IN_SIZE_W-1:0] out_leftover_r;

  logic                 in_acc;
  logic                 out_free;
  logic                 issue;
  logic                 done_fire;
  logic                 take;
  logic                 mode_ok;
  logic                 load_ok;
  logic [KW-1:0]        act_n;
  logic [KW-1:0]        start;
  logic [31:0]          idx_m1;
  logic [31:0]          pick_ext;
  logic [AW-1:0]        load_a;
  logic [WW-1:0]        psz_ext;
  logic [KW-1:0]        ctr_m1;
  logic [KW-1:0]        rk_m1;
  logic [KW-1:0]        pk_m1;
  logic [AW-1:0]        ra;
  logic [AW-1:0]        rsel;
  logic [AW-1:0]        pa;
  logic [SIZE_BITS-1:0] sz_now;
  logic [WW-1:0]        left_w;
  cmp_ctl_t             cmp_ctl;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  logic [SIZE_BITS-1:0] mem_wd;

  // Hold new requests off for the whole scan and until its result is posted.
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign done_fire = (state_r == S_DONE) && out_free;
  assign mode_ok   = (fit_mode_r <= MODE_WORST_DYN);

  // Clamp the partition count to the table depth.
  assign act_n = (32'(pcount_r) > MAX_PARTS) ? KW'(MAX_PARTS) : KW'(pcount_r);
  // Next fit starts at the pointer, every other mode at partition 1.
  assign start = (fit_mode_r == MODE_NEXT) ? ptr_r : KW'(1);

  // Load address: partition numbers are 1-based, drop anything off the table.
  assign load_ok = (32'(in_part_index) >= 32'd1) && (32'(in_part_index) <= MAX_PARTS);
  assign idx_m1  = 32'(in_part_index) - 32'd1;
  assign load_a  = idx_m1[AW-1:0];
  assign psz_ext = WW'(in_part_size);

  // Scan addressing: issue one read per cycle, compare it the cycle after.
  assign issue  = (state_r == S_SCAN) && (ctr_r <= end_r);
  assign ctr_m1 = ctr_r - KW'(1);
  assign ra     = ctr_m1[AW-1:0];
  assign rk_m1  = rd_k_r - KW'(1);
  assign rsel   = rk_m1[AW-1:0];
  assign pk_m1  = pick_r - KW'(1);
  assign pa     = pk_m1[AW-1:0];
  // An entry never loaded reads as size zero.
  assign sz_now = vld_r[rsel] ? rd_data_r : '0;

  assign left_w   = WW'(best_r) - WW'(job_r);
  assign pick_ext = 32'(pick_r);

  always_comb begin
    cmp_ctl.use_taken = (fit_mode_r != MODE_WORST_DYN);
    cmp_ctl.want_min  = (fit_mode_r == MODE_BEST);
    cmp_ctl.want_max  = (fit_mode_r == MODE_WORST) || (fit_mode_r == MODE_WORST_DYN);
    cmp_ctl.have_pick = (pick_r != '0);
  end

  pfa_cmp #(
    .W(WW)
  ) u_cmp (
    .ctl   (cmp_ctl),
    .size  (WW'(sz_now)),
    .job   (WW'(job_r)),
    .best  (WW'(best_r)),
    .taken (taken_r[rsel]),
    .take  (take)
  );

  // Single write port: loads from idle, shrink of the chosen partition at the end in dynamic worst fit.
  always_comb begin
    mem_we = (in_acc && (in_req_type == REQ_LOAD) && load_ok) ||
             (done_fire && (pick_r != '0) && (fit_mode_r == MODE_WORST_DYN));
    mem_wa = (state_r == S_IDLE) ? load_a : pa;
    mem_wd = (state_r == S_IDLE) ? psz_ext[SIZE_BITS-1:0] : left_w[SIZE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (issue) begin
      rd_data_r <= mem[ra];
    end
    rd_k_r <= ctr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fit_mode_r  <= MODE_FIRST;
      pcount_r    <= COUNT_W'(16);
      ptr_r       <= KW'(1);
      taken_r     <= '0;
      vld_r       <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FIT_MODE:   fit_mode_r <= cfg_data[MODE_W-1:0];
          CFG_PART_COUNT: pcount_r   <= cfg_data[COUNT_W-1:0];
        endcase
      end

      // Drop the result once taken; a new one below overrides.
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      rd_v_r <= issue;

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_req_type == REQ_LOAD) begin
              // Load: clear the taken flag and rewind the next-fit pointer.
              if (load_ok) begin
                taken_r[load_a] <= 1'b0;
                vld_r[load_a]   <= 1'b1;
                ptr_r           <= KW'(1);
              end
            end else begin
              pick_r <= '0;
              job_r  <= in_job_size;
              end_r  <= act_n;
              ctr_r  <= start;
              // Skip straight to the result when there is nothing to scan.
              if (mode_ok && (start <= act_n)) begin
                state_r <= S_SCAN;
              end else begin
                state_r <= S_DONE;
              end
            end
          end
        end
        S_SCAN: begin
          if (rd_v_r && take) begin
            pick_r <= rd_k_r;
            best_r <= sz_now;
          end
          if (issue) begin
            ctr_r <= ctr_r + KW'(1);
          end
          // Last read compared this cycle: advance to the result.
          if (rd_v_r && !issue) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r       <= 1'b1;
            out_granted_r     <= (pick_r != '0);
            out_part_number_r <= pick_ext[INDEX_W-1:0];
            out_leftover_r    <= (pick_r != '0) ? left_w[IN_SIZE_W-1:0] : '0;
            if (pick_r != '0) begin
              taken_r[pa] <= 1'b1;
              if (fit_mode_r == MODE_WORST_DYN) begin
                vld_r[pa] <= 1'b1;
              end
            end
            // Next fit rests on the chosen partition, or parks past the end.
            if (fit_mode_r == MODE_NEXT) begin
              ptr_r <= (pick_r != '0) ? pick_r : end_r + KW'(1);
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_granted     = out_granted_r;
  assign out_part_number = out_part_number_r;
  assign out_leftover    = out_leftover_r;

  `PFA_ASSERT_IMPL(a_pick_in_range, state_r == S_DONE, pick_r <= end_r, "pick beyond scan end")
  `PFA_ASSERT_IMPL(a_ctr_bound, state_r == S_SCAN, ctr_r <= end_r + KW'(1),
                   "scan counter overran")
  `PFA_ASSERT_IMPL(a_grant_fits, (state_r == S_DONE) && (pick_r != '0),
                   WW'(best_r) >= WW'(job_r), "granted partition too small")
  `PFA_ASSERT_NEXT(a_result_posted, done_fire, out_valid_r && (state_r == S_IDLE), "result not posted")

endmodule

>>> tb/placement_checker.sv
`timescale 1ns / 1ps

module placement_checker
  import pfa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_req_type,
  input  logic [INDEX_W-1:0]    in_part_index,
  input  logic [IN_SIZE_W-1:0]  in_part_size,
  input  logic [IN_SIZE_W-1:0]  in_job_size,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  out_granted,
  input  logic [INDEX_W-1:0]    out_part_number,
  input  logic [IN_SIZE_W-1:0]  out_leftover,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    outstanding
);

  localparam int PARTS = 16;

  typedef struct packed {
    logic                 granted;
    logic [INDEX_W-1:0]   part_number;
    logic [IN_SIZE_W-1:0] leftover;
  } placement_t;

  logic [IN_SIZE_W-1:0] size_tab [1:PARTS];
  logic                 taken    [1:PARTS];
  logic [INDEX_W-1:0]   next_ptr;
  logic [MODE_W-1:0]    mode;
  logic [COUNT_W-1:0]   count;
  placement_t           placements_due [$];
  int                   mismatches = 0;

  function automatic int scanned_parts();
    return (count > PARTS) ? PARTS : int'(count);
  endfunction

  function automatic int first_free(input logic [IN_SIZE_W-1:0] job, input int start);
    for (int k = start; k <= scanned_parts(); k++)
      if (!taken[k] && size_tab[k] >= job) return k;
    return 0;
  endfunction

  // Lowest index wins a tie, since only a strict improvement replaces the pick.
  function automatic int extreme_fit(input logic [IN_SIZE_W-1:0] job, input bit want_max,
                                     input bit skip_taken);
    int pick;
    int pick_waste;
    int waste;
    pick = 0;
    pick_waste = 0;
    for (int k = 1; k <= scanned_parts(); k++) begin
      if (skip_taken && taken[k]) continue;
      if (size_tab[k] < job) continue;
      waste = int'(size_tab[k]) - int'(job);
      if (pick == 0 || (want_max ? (waste > pick_waste) : (waste < pick_waste))) begin
        pick = k;
        pick_waste = waste;
      end
    end
    return pick;
  endfunction

  function automatic placement_t place_job(input logic [IN_SIZE_W-1:0] job);
    placement_t r;
    int pick;
    pick = 0;
    case (mode)
      MODE_FIRST:     pick = first_free(job, 1);
      MODE_NEXT: begin
        pick = first_free(job, int'(next_ptr));
        next_ptr = (pick != 0) ? INDEX_W'(pick) : INDEX_W'(scanned_parts() + 1);
      end
      MODE_BEST:      pick = extreme_fit(job, 1'b0, 1'b1);
      MODE_WORST:     pick = extreme_fit(job, 1'b1, 1'b1);
      MODE_WORST_DYN: pick = extreme_fit(job, 1'b1, 1'b0);
      default:        pick = 0;
    endcase
    r = '0;
    if (pick != 0) begin
      r.granted     = 1'b1;
      r.part_number = INDEX_W'(pick);
      r.leftover    = size_tab[pick] - job;
      taken[pick]   = 1'b1;
      if (mode == MODE_WORST_DYN) size_tab[pick] = r.leftover;
    end
    return r;
  endfunction

  task automatic report(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    placement_t want;
    if (!rst_n) begin
      for (int k = 1; k <= PARTS; k++) begin
        size_tab[k] = '0;
        taken[k]    = 1'b0;
      end
      next_ptr = INDEX_W'(1);
      mode     = MODE_FIRST;
      count    = COUNT_W'(PARTS);
      placements_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_FIT_MODE) mode = cfg_data[MODE_W-1:0];
        else count = cfg_data[COUNT_W-1:0];
      end
      if (out_valid && !out_stall) begin
        if (placements_due.size() == 0) begin
          report($sformatf("unexpected result granted=%0d part=%0d leftover=%0d",
                           out_granted, out_part_number, out_leftover));
        end else begin
          want = placements_due.pop_front();
          if (out_granted !== want.granted)
            report($sformatf("granted %0d, expected %0d", out_granted, want.granted));
          if (out_part_number !== want.part_number)
            report($sformatf("part_number %0d, expected %0d",
                             out_part_number, want.part_number));
          if (out_leftover !== want.leftover)
            report($sformatf("leftover %0d, expected %0d", out_leftover, want.leftover));
        end
      end
      if (in_valid && !in_stall) begin
        if (in_req_type == REQ_LOAD) begin
          if (in_part_index >= 1 && in_part_index <= PARTS) begin
            size_tab[in_part_index] = in_part_size;
            taken[in_part_index]    = 1'b0;
            next_ptr                = INDEX_W'(1);
          end
        end else begin
          placements_due.push_back(place_job(in_job_size));
        end
      end
    end
    outstanding <= placements_due.size();
    fail_count  <= mismatches;
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pfa_pkg::*;

  // Stimulus sizing and timing. The settle time between phases covers one
  // allocate scan with margin.
  localparam int RANDOM_ITEMS  = 450;
  localparam int SETTLE_CYCLES = 24;
  localparam int DRAIN_CYCLES  = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_LIMIT    = 3000;
  localparam int HOLD_PHASE    = 6;

  // No package name exists for the unused modes; 7 is the top of that range.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_req_type;
  logic [INDEX_W-1:0]    in_part_index;
  logic [IN_SIZE_W-1:0]  in_part_size;
  logic [IN_SIZE_W-1:0]  in_job_size;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_granted;
  logic [INDEX_W-1:0]    out_part_number;
  logic [IN_SIZE_W-1:0]  out_leftover;
  logic                  cfg_we;
  logic                  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int   fail_count;
  int   outstanding;
  int   idle_cycles = 0;
  logic hold_request;

  // Sender pacing state and a rough record of loaded sizes, used only to
  // aim job sizes at exact and near fits.
  int                   burst_left = 0;
  bit                   steady = 1'b0;
  logic [IN_SIZE_W-1:0] loaded_size [1:16];

  partition_fit_allocator DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_part_index   (in_part_index),
    .in_part_size    (in_part_size),
    .in_job_size     (in_job_size),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_granted     (out_granted),
    .out_part_number (out_part_number),
    .out_leftover    (out_leftover),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  placement_checker placement_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_part_index   (in_part_index),
    .in_part_size    (in_part_size),
    .in_job_size     (in_job_size),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_granted     (out_granted),
    .out_part_number (out_part_number),
    .out_leftover    (out_leftover),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .outstanding     (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: stall in segments of changing style; serve one long hold-off
  // when asked, so the block backs up and stalls its input.
  initial begin
    int seg_left;
    int seg_style;
    bit hold_served;
    seg_left    = 0;
    seg_style   = 0;
    hold_served = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_served) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_served = 1'b1;
        seg_left    = 0;
      end else begin
        if (seg_left == 0) begin
          seg_style = $urandom_range(0, 3);
          seg_left  = $urandom_range(16, 160);
        end
        seg_left--;
        case (seg_style)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((seg_left % 4) == 0);
        endcase
      end
    end
  end

  // Offer one request and hold it until accepted, then pace the next one:
  // bursts of back-to-back requests with random gaps between them, or no gaps when steady.
  task automatic offer(input logic req, input logic [INDEX_W-1:0] idx,
                       input logic [IN_SIZE_W-1:0] psz, input logic [IN_SIZE_W-1:0] job);
    int gap;
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_part_index <= idx;
    in_part_size  <= psz;
    in_job_size   <= job;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (steady) begin
      gap = 0;
    end else if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      burst_left = $urandom_range(0, 11);
      gap = $urandom_range(1, 8);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_part(input logic [INDEX_W-1:0] idx, input logic [IN_SIZE_W-1:0] psz);
    if (idx >= 1 && idx <= 16) loaded_size[idx] = psz;
    offer(REQ_LOAD, idx, psz, IN_SIZE_W'($urandom_range(0, 65535)));
  endtask

  task automatic alloc_job(input logic [IN_SIZE_W-1:0] job);
    offer(REQ_ALLOC, INDEX_W'($urandom_range(0, 31)), IN_SIZE_W'($urandom_range(0, 65535)),
          job);
  endtask

  // Drop valid, let the checker count the last request, wait for every
  // placement to come back, then give the block time to go idle.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back; only call while the block is idle.
  task automatic program_regs(input logic [MODE_W-1:0] mode_code,
                              input logic [COUNT_W-1:0] count_val);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FIT_MODE;
    cfg_data  <= {2'($urandom_range(0, 3)), mode_code};
    @(posedge clk);
    cfg_index <= CFG_PART_COUNT;
    cfg_data  <= count_val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Sizes cluster on a few round values so ties show up often.
  function automatic logic [IN_SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return IN_SIZE_W'($urandom_range(1, 8) * 100);
      default: return IN_SIZE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [IN_SIZE_W-1:0] pick_job();
    int r;
    int shave;
    logic [IN_SIZE_W-1:0] base;
    r     = $urandom_range(0, 19);
    shave = $urandom_range(0, 50);
    base  = loaded_size[$urandom_range(1, 16)];
    if (r < 10) return base;
    if (r < 15) return (base > shave) ? base - IN_SIZE_W'(shave) : '0;
    if (r < 18) return IN_SIZE_W'($urandom_range(0, 65535));
    return ($urandom_range(0, 1) != 0) ? '1 : '0;
  endfunction

  initial begin
    int phase;
    int random_sent;
    int r;
    logic [MODE_W-1:0]  mode_code;
    logic [COUNT_W-1:0] count_val;

    phase       = 0;
    random_sent = 0;
    for (int k = 1; k <= 16; k++) loaded_size[k] = '0;

    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_req_type   <= REQ_LOAD;
    in_part_index <= '0;
    in_part_size  <= '0;
    in_job_size   <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_FIT_MODE;
    cfg_data      <= '0;
    hold_request  <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: first fit with size extremes and ignored load indexes.
    program_regs(MODE_FIRST, 5'd16);
    load_part(5'd1, 16'd100);
    load_part(5'd2, 16'd500);
    load_part(5'd3, 16'd200);
    load_part(5'd16, 16'hFFFF);
    load_part(5'd0, 16'd7);
    load_part(5'd31, 16'd9);
    load_part(5'd17, 16'd3);
    alloc_job(16'd150);
    alloc_job(16'd0);
    alloc_job(16'hFFFF);
    alloc_job(16'd300);
    settle();

    // Next fit: a load rewinds the pointer, then run it past the end.
    program_regs(MODE_NEXT, 5'd16);
    load_part(5'd3, 16'd200);
    alloc_job(16'd50);
    alloc_job(16'd50);
    alloc_job(16'd0);
    settle();

    program_regs(MODE_BEST, 5'd16);
    load_part(5'd4, 16'd120);
    alloc_job(16'd100);
    settle();

    // No partitions in use: every job is refused.
    program_regs(MODE_WORST_DYN, 5'd0);
    alloc_job(16'd0);
    settle();

    // Count above the table size acts as the full table; dynamic shrink.
    program_regs(MODE_WORST_DYN, 5'd31);
    alloc_job(16'd1000);
    alloc_job(16'hFFFF);
    settle();

    program_regs(MODE_UNUSED, 5'd16);
    alloc_job(16'd0);
    settle();

    program_regs(MODE_WORST, 5'd4);
    alloc_job(16'd10);
    settle();

    // Random phases: each loads a table, then mixes allocates with reloads
    // and a little noise on bad indexes.
    while (random_sent < RANDOM_ITEMS) begin
      if (phase < 10) begin
        mode_code = MODE_W'(phase % 5);
      end else if ($urandom_range(0, 15) == 0) begin
        mode_code = MODE_W'($urandom_range(5, 7));
      end else begin
        mode_code = MODE_W'($urandom_range(0, 4));
      end
      r = $urandom_range(0, 19);
      if (phase % 4 == 1)      count_val = 5'd1;
      else if (phase % 4 == 2) count_val = 5'd16;
      else if (r == 0)         count_val = 5'd0;
      else if (r < 3)          count_val = COUNT_W'($urandom_range(17, 31));
      else                     count_val = COUNT_W'($urandom_range(2, 16));
      program_regs(mode_code, count_val);

      steady = ($urandom_range(0, 3) == 0);
      if (phase == HOLD_PHASE) hold_request <= 1'b1;

      repeat ($urandom_range(2, 16)) begin
        load_part(INDEX_W'($urandom_range(1, 16)), pick_size());
        random_sent++;
      end
      repeat (24) begin
        r = $urandom_range(0, 9);
        if (r < 7) begin
          alloc_job(pick_job());
          random_sent++;
        end else if (r < 9) begin
          load_part(INDEX_W'($urandom_range(1, 16)), pick_size());
          random_sent++;
        end else begin
          load_part(($urandom_range(0, 1) != 0) ? INDEX_W'(0) : INDEX_W'($urandom_range(17, 31)),
                    pick_size());
        end
      end
      settle();
      phase++;
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/pfa_pkg.sv
sv/pfa_cmp.sv
sv/partition_fit_allocator.sv
tb/placement_checker.sv
tb/testbench.sv
